[hdl/tcw_pkg.sv]
package tcw_pkg;

	localparam int COLUMNS_DEF    = 80;
	localparam int ROWS_DEF       = 25;
	localparam int TAB_BLANKS_DEF = 5;

	localparam logic [7:0] BLANK_CHAR  = 8'h20;
	localparam logic [7:0] SCROLL_ATTR = 8'h07;
	localparam logic [7:0] RESET_COLOR = 8'h0f;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	typedef enum logic [1:0] {
		K_PUT   = 2'd0,
		K_CLEAR = 2'd1,
		K_FILL  = 2'd2,
		K_READ  = 2'd3
	} tcw_kind_t;

	typedef enum logic [2:0] {
		CC_PRINT = 3'd0,
		CC_BS    = 3'd1,
		CC_CR    = 3'd2,
		CC_LF    = 3'd3,
		CC_TAB   = 3'd4
	} tcw_cls_t;

	typedef enum logic [3:0] {
		DP_NONE   = 4'd0,
		DP_INIT   = 4'd1,
		DP_CLEAR  = 4'd2,
		DP_FILL   = 4'd3,
		DP_SCROLL = 4'd4,
		DP_PUT    = 4'd5,
		DP_BS     = 4'd6,
		DP_CR     = 4'd7,
		DP_LF     = 4'd8,
		DP_HOME   = 4'd9,
		DP_READ   = 4'd10
	} tcw_op_t;

	typedef struct packed {
		logic    item_load;
		logic    sweep_clr;
		logic    sweep_inc;
		logic    load_out;
		tcw_op_t op;
	} tcw_cmd_t;

	typedef struct packed {
		tcw_kind_t kind;
		tcw_cls_t  cls;
		logic      col_last;
		logic      row_last;
		logic      rep_last;
		logic      rep_zero;
		logic      sweep_end;
	} tcw_sts_t;

	function automatic tcw_cls_t code_class(input logic [7:0] code);
		tcw_cls_t c;
		case (code)
			CH_BS:   c = CC_BS;
			CH_TAB:  c = CC_TAB;
			CH_LF:   c = CC_LF;
			CH_CR:   c = CC_CR;
			default: c = CC_PRINT;
		endcase
		return c;
	endfunction

endpackage

[hdl/tcw_dp.sv]
module tcw_dp import tcw_pkg::*; #(
	parameter int COLUMNS    = COLUMNS_DEF,
	parameter int ROWS       = ROWS_DEF,
	parameter int TAB_BLANKS = TAB_BLANKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tcw_kind_t   kind,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr,
	input  logic [10:0] cell_index,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  tcw_cmd_t    cmd,
	output tcw_sts_t    sts,
	output logic [31:0] m_tdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int CLW   = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = $clog2(CELLS + 1);
	localparam int TW    = $clog2(TAB_BLANKS + 1);

	logic [7:0]  char_mem [CELLS];
	logic [7:0]  attr_mem [CELLS];

	tcw_kind_t   kind_q;
	logic [7:0]  code_q;
	logic [7:0]  attr_q;
	logic [10:0] idx_q;
	logic [TW-1:0]  rep_q;
	logic [CLW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic [SW-1:0]  sweep_q;
	logic [7:0]  dcolor_q;
	logic [7:0]  rdc_q;
	logic [7:0]  rda_q;
	logic [31:0] m_tdata_q;

	logic          wr_vld_s1;
	logic          wr_copy_s1;
	logic [AW-1:0] wr_addr_s1;

	tcw_cls_t      cls;
	tcw_cls_t      in_cls;
	logic [31:0]   pos32;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] sweep_addr;
	logic          sweep_in;
	logic          sweep_copy;
	logic          col_last;
	logic          row_last;
	logic          in_rng;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          cw;
	logic          aw;
	logic [AW-1:0] waddr;
	logic [7:0]    wchar;
	logic [7:0]    wattr;
	logic [7:0]    out_char;
	logic [7:0]    out_attr;

	assign cls        = code_class(code_q);
	assign in_cls     = code_class(char_code);
	assign pos32      = 32'(row_q) * COLUMNS + 32'(col_q);
	assign cur_addr   = AW'(pos32);
	assign sweep_addr = sweep_q[AW-1:0];
	assign sweep_in   = sweep_q < SW'(CELLS);
	assign sweep_copy = sweep_q < SW'(CELLS - COLUMNS);
	assign col_last   = col_q == CLW'(COLUMNS - 1);
	assign row_last   = row_q == RW'(ROWS - 1);
	assign in_rng     = 32'(idx_q) < CELLS;

	assign sts.kind      = kind_q;
	assign sts.cls       = cls;
	assign sts.col_last  = col_last;
	assign sts.row_last  = row_last;
	assign sts.rep_last  = rep_q == TW'(1);
	assign sts.rep_zero  = rep_q == '0;
	assign sts.sweep_end = sweep_q == SW'(CELLS);

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q <= kind;
			code_q <= char_code;
			attr_q <= attr;
			idx_q  <= cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcolor_q <= RESET_COLOR;
		end else if (cfg_we) begin
			dcolor_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			rep_q   <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.item_load) begin
				if (kind != K_PUT) begin
					rep_q <= '0;
				end else if (in_cls == CC_TAB) begin
					rep_q <= TW'(TAB_BLANKS);
				end else if (in_cls == CC_PRINT) begin
					rep_q <= TW'(1);
				end else begin
					rep_q <= '0;
				end
			end
			if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.sweep_inc) begin
				sweep_q <= sweep_q + SW'(1);
			end
			case (cmd.op)
				DP_PUT: begin
					rep_q <= rep_q - TW'(1);
					if (col_last) begin
						col_q <= '0;
						if (!row_last) begin
							row_q <= row_q + RW'(1);
						end
					end else begin
						col_q <= col_q + CLW'(1);
					end
				end
				DP_BS: begin
					if (col_q != '0) begin
						col_q <= col_q - CLW'(1);
					end
				end
				DP_CR: begin
					col_q <= '0;
				end
				DP_LF: begin
					col_q <= '0;
					if (!row_last) begin
						row_q <= row_q + RW'(1);
					end
				end
				DP_HOME: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(32'(idx_q));
		if (cmd.op == DP_SCROLL && sweep_copy) begin
			rd_en   = 1'b1;
			rd_addr = AW'(32'(sweep_q) + COLUMNS);
		end else if (cmd.op == DP_READ && in_rng) begin
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_s1 <= 1'b0;
		end else begin
			wr_vld_s1 <= cmd.op == DP_SCROLL && sweep_in;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= sweep_addr;
		wr_copy_s1 <= sweep_copy;
	end

	always_comb begin
		cw    = 1'b0;
		aw    = 1'b0;
		waddr = sweep_addr;
		wchar = BLANK_CHAR;
		wattr = SCROLL_ATTR;
		if (wr_vld_s1) begin
			cw    = 1'b1;
			aw    = 1'b1;
			waddr = wr_addr_s1;
			if (wr_copy_s1) begin
				wchar = rdc_q;
				wattr = rda_q;
			end
		end else begin
			case (cmd.op)
				DP_INIT: begin
					cw = sweep_in;
					aw = sweep_in;
				end
				DP_CLEAR: begin
					cw = sweep_in;
				end
				DP_FILL: begin
					aw    = sweep_in;
					wattr = attr_q;
				end
				DP_PUT: begin
					cw    = 1'b1;
					aw    = 1'b1;
					waddr = cur_addr;
					wchar = (cls == CC_TAB) ? BLANK_CHAR : code_q;
					wattr = attr_q;
				end
				DP_BS: begin
					cw    = col_q != '0;
					aw    = col_q != '0;
					waddr = cur_addr - AW'(1);
					wattr = dcolor_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cw) begin
			char_mem[waddr] <= wchar;
		end
		if (aw) begin
			attr_mem[waddr] <= wattr;
		end
		if (rd_en) begin
			rdc_q <= char_mem[rd_addr];
			rda_q <= attr_mem[rd_addr];
		end
	end

	assign out_char = (kind_q == K_READ && in_rng) ? rdc_q : 8'd0;
	assign out_attr = (kind_q == K_READ && in_rng) ? rda_q : 8'd0;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= {5'd0, out_attr, out_char, pos32[10:0]};
		end
	end

	assign m_tdata = m_tdata_q;

`ifndef SYNTH
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < COLUMNS) && (row_q < ROWS))
		else $error("cursor out of range");

	a_copy_stage: assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_s1 |-> $past(cmd.op == DP_SCROLL))
		else $error("copy write without scroll");
`endif

endmodule

[hdl/tcw_ctrl.sv]
module tcw_ctrl import tcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  tcw_sts_t sts,
	output tcw_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_INIT   = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_EXEC   = 8'b0000_0100,
		S_WRITE  = 8'b0000_1000,
		S_SCROLL = 8'b0001_0000,
		S_CLEAR  = 8'b0010_0000,
		S_FILL   = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   m_tvalid_q;

	always_comb begin
		cmd      = '0;
		nxt      = state_q;
		s_tready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.op        = DP_INIT;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_end) begin
					nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.item_load = 1'b1;
					cmd.sweep_clr = 1'b1;
					nxt           = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.kind)
					K_PUT: begin
						case (sts.cls)
							CC_BS: begin
								cmd.op = DP_BS;
								nxt    = S_RESULT;
							end
							CC_CR: begin
								cmd.op = DP_CR;
								nxt    = S_RESULT;
							end
							CC_LF: begin
								cmd.op = DP_LF;
								nxt    = sts.row_last ? S_SCROLL : S_RESULT;
							end
							default: begin
								nxt = S_WRITE;
							end
						endcase
					end
					K_CLEAR: begin
						cmd.op = DP_HOME;
						nxt    = S_CLEAR;
					end
					K_FILL: begin
						nxt = S_FILL;
					end
					K_READ: begin
						cmd.op = DP_READ;
						nxt    = S_RESULT;
					end
					default: begin
						nxt = S_RESULT;
					end
				endcase
			end
			S_WRITE: begin
				cmd.op        = DP_PUT;
				cmd.sweep_clr = 1'b1;
				if (sts.col_last && sts.row_last) begin
					nxt = S_SCROLL;
				end else if (sts.rep_last) begin
					nxt = S_RESULT;
				end
			end
			S_SCROLL: begin
				cmd.op        = DP_SCROLL;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_end) begin
					nxt = sts.rep_zero ? S_RESULT : S_WRITE;
				end
			end
			S_CLEAR: begin
				cmd.op        = DP_CLEAR;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_end) begin
					nxt = S_RESULT;
				end
			end
			S_FILL: begin
				cmd.op        = DP_FILL;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_end) begin
					nxt = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					nxt          = S_IDLE;
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

`ifndef SYNTH
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && s_tvalid) |=> (state_q == S_EXEC))
		else $error("accepted request not executed");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid_q || m_tready))
		else $error("result overwrites pending result");

	a_scroll_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCROLL && !sts.sweep_end) |=> (state_q == S_SCROLL))
		else $error("scroll left early");
`endif

endmodule

[hdl/text_console_writer.sv]
// Character-cell console: a ROWS x COLUMNS store of character/attribute cells with a cursor.
// Each request on the slave stream is one operation (put character, clear, fill attributes,
// read cell) and yields exactly one result on the master stream carrying the cursor position.
// After reset the block blanks the whole store with s_tready low, and a tab puts TAB_BLANKS
// blanks. Every scroll, clear and fill walks the whole store through the single write port
// of the cell memory, one cell per cycle.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS    = COLUMNS_DEF,
	parameter int ROWS       = ROWS_DEF,
	parameter int TAB_BLANKS = TAB_BLANKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code[7:0], attr[15:8], cell_index[26:16], zero
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cursor_pos[10:0], read_char[18:11], read_attr[26:19], zero
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	tcw_cmd_t cmd;
	tcw_sts_t sts;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcw_dp #(
		.COLUMNS    (COLUMNS),
		.ROWS       (ROWS),
		.TAB_BLANKS (TAB_BLANKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (tcw_kind_t'(s_tuser)),
		.char_code  (s_tdata[7:0]),
		.attr       (s_tdata[15:8]),
		.cell_index (s_tdata[26:16]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.sts        (sts),
		.m_tdata    (m_tdata)
	);

endmodule
